FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define SC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sc1kd_pkg.sv
package sc1kd_pkg;

	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam logic [7:0] RELEASE_BIT = 8'h80;
	localparam logic [7:0] INDEX_MASK  = 8'h7F;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_DOWN_EN = 2'd0,
		REG_KEY_UP_EN   = 2'd1
	} cfg_reg_t;

	localparam logic [7:0] VK_MENU     = 8'h12;
	localparam logic [7:0] VK_CAPITAL  = 8'h14;
	localparam logic [7:0] VK_LWIN     = 8'h5B;
	localparam logic [7:0] VK_RWIN     = 8'h5C;
	localparam logic [7:0] VK_NUMLOCK  = 8'h90;
	localparam logic [7:0] VK_SCROLL   = 8'h91;
	localparam logic [7:0] VK_LSHIFT   = 8'hA0;
	localparam logic [7:0] VK_RSHIFT   = 8'hA1;
	localparam logic [7:0] VK_LCONTROL = 8'hA2;
	localparam logic [7:0] VK_RCONTROL = 8'hA3;
	localparam logic [7:0] VK_LMENU    = 8'hA4;

	typedef struct packed {
		logic ext;
		logic alt;
		logic ctrl;
		logic shift;
		logic win;
		logic caps;
		logic num;
		logic scroll;
	} mods_t;

	typedef struct packed {
		logic [7:0] vk_code;
		logic [6:0] ascii;
		logic       released;
		logic       alt_held;
		logic       ctrl_held;
		logic       shift_held;
	} result_t;

	typedef struct packed {
		logic [6:0] norm;
		logic [6:0] shft;
		logic [6:0] caps;
		logic [6:0] nlck;
	} chars_t;

	function automatic logic [7:0] plain_vk(input logic [6:0] idx);
		logic [7:0] v;
		case (idx)
			7'h01: v = 8'h1B; 7'h02: v = 8'h31; 7'h03: v = 8'h32; 7'h04: v = 8'h33;
			7'h05: v = 8'h34; 7'h06: v = 8'h35; 7'h07: v = 8'h36; 7'h08: v = 8'h37;
			7'h09: v = 8'h38; 7'h0A: v = 8'h39; 7'h0B: v = 8'h30; 7'h0C: v = 8'hBD;
			7'h0D: v = 8'hBB; 7'h0E: v = 8'h08; 7'h0F: v = 8'h09;
			7'h10: v = 8'h51; 7'h11: v = 8'h57; 7'h12: v = 8'h45; 7'h13: v = 8'h52;
			7'h14: v = 8'h54; 7'h15: v = 8'h59; 7'h16: v = 8'h55; 7'h17: v = 8'h49;
			7'h18: v = 8'h4F; 7'h19: v = 8'h50; 7'h1A: v = 8'hDB; 7'h1B: v = 8'hDD;
			7'h1C: v = 8'h0D; 7'h1D: v = 8'hA2; 7'h1E: v = 8'h41; 7'h1F: v = 8'h53;
			7'h20: v = 8'h44; 7'h21: v = 8'h46; 7'h22: v = 8'h47; 7'h23: v = 8'h48;
			7'h24: v = 8'h4A; 7'h25: v = 8'h4B; 7'h26: v = 8'h4C; 7'h27: v = 8'hBA;
			7'h28: v = 8'hDE; 7'h29: v = 8'hC0; 7'h2A: v = 8'hA0; 7'h2B: v = 8'hDC;
			7'h2C: v = 8'h5A; 7'h2D: v = 8'h58; 7'h2E: v = 8'h43; 7'h2F: v = 8'h56;
			7'h30: v = 8'h42; 7'h31: v = 8'h4E; 7'h32: v = 8'h4D; 7'h33: v = 8'hBC;
			7'h34: v = 8'hBE; 7'h35: v = 8'hE2; 7'h36: v = 8'hA1; 7'h37: v = 8'h6A;
			7'h38: v = 8'hA4; 7'h39: v = 8'h20; 7'h3A: v = 8'h14; 7'h3B: v = 8'h70;
			7'h3C: v = 8'h71; 7'h3D: v = 8'h72; 7'h3E: v = 8'h73; 7'h3F: v = 8'h74;
			7'h40: v = 8'h75; 7'h41: v = 8'h76; 7'h42: v = 8'h77; 7'h43: v = 8'h78;
			7'h44: v = 8'h79; 7'h45: v = 8'h90; 7'h46: v = 8'h91; 7'h47: v = 8'h67;
			7'h48: v = 8'h68; 7'h49: v = 8'h69; 7'h4A: v = 8'h6D; 7'h4B: v = 8'h64;
			7'h4C: v = 8'h65; 7'h4D: v = 8'h66; 7'h4E: v = 8'h6B; 7'h4F: v = 8'h61;
			7'h50: v = 8'h62; 7'h51: v = 8'h63; 7'h52: v = 8'h60; 7'h53: v = 8'h6E;
			7'h57: v = 8'h7A; 7'h58: v = 8'h7B;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] ext_vk(input logic [6:0] idx);
		logic [7:0] v;
		case (idx)
			7'h10: v = 8'hB1; 7'h19: v = 8'hB0; 7'h1C: v = 8'h0D; 7'h1D: v = 8'hA3;
			7'h20: v = 8'hAD; 7'h21: v = 8'hB7; 7'h22: v = 8'hB3; 7'h2E: v = 8'hAE;
			7'h30: v = 8'hAF; 7'h32: v = 8'hAC; 7'h35: v = 8'h6F; 7'h38: v = 8'h12;
			7'h47: v = 8'h24; 7'h48: v = 8'h26; 7'h49: v = 8'h21; 7'h4B: v = 8'h25;
			7'h4D: v = 8'h27; 7'h4F: v = 8'h23; 7'h50: v = 8'h28; 7'h51: v = 8'h22;
			7'h52: v = 8'h2D; 7'h53: v = 8'h2E; 7'h5B: v = 8'h5B; 7'h5C: v = 8'h5C;
			7'h5D: v = 8'h5D; 7'h5F: v = 8'h5F; 7'h65: v = 8'hAA; 7'h66: v = 8'hAB;
			7'h67: v = 8'hA8; 7'h68: v = 8'hA9; 7'h69: v = 8'hA7; 7'h6A: v = 8'hA6;
			7'h6C: v = 8'hB4; 7'h6D: v = 8'hB5;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Character columns per key: normal, shifted, caps, numlock.
	function automatic chars_t char_cols(input logic [7:0] vk);
		chars_t c;
		c = '0;
		if (vk >= 8'h41 && vk <= 8'h5A) begin
			c.norm = 7'(vk + 8'h20);
			c.shft = vk[6:0];
			c.caps = vk[6:0];
		end else begin
			case (vk)
				8'h1B: c.norm = 7'h1B;
				8'hC0: begin c.norm = 7'h60; c.shft = 7'h7E; end
				8'h31: begin c.norm = 7'h31; c.shft = 7'h21; end
				8'h32: begin c.norm = 7'h32; c.shft = 7'h40; end
				8'h33: begin c.norm = 7'h33; c.shft = 7'h23; end
				8'h34: begin c.norm = 7'h34; c.shft = 7'h24; end
				8'h35: begin c.norm = 7'h35; c.shft = 7'h25; end
				8'h36: begin c.norm = 7'h36; c.shft = 7'h5E; end
				8'h37: begin c.norm = 7'h37; c.shft = 7'h26; end
				8'h38: begin c.norm = 7'h38; c.shft = 7'h2A; end
				8'h39: begin c.norm = 7'h39; c.shft = 7'h28; end
				8'h30: begin c.norm = 7'h30; c.shft = 7'h29; end
				8'hBD: begin c.norm = 7'h2D; c.shft = 7'h5F; end
				8'hBB: begin c.norm = 7'h3D; c.shft = 7'h2B; end
				8'h08: c.norm = 7'h08;
				8'h09: c.norm = 7'h09;
				8'hDB: begin c.norm = 7'h5B; c.shft = 7'h7B; end
				8'hDD: begin c.norm = 7'h5D; c.shft = 7'h7D; end
				8'hDC: begin c.norm = 7'h5C; c.shft = 7'h7C; end
				8'hBA: begin c.norm = 7'h3B; c.shft = 7'h3A; end
				8'hDE: begin c.norm = 7'h27; c.shft = 7'h22; end
				8'h0D: c.norm = 7'h0A;
				8'hBC: begin c.norm = 7'h2C; c.shft = 7'h3C; end
				8'hBE: begin c.norm = 7'h2E; c.shft = 7'h3E; end
				8'hE2: begin c.norm = 7'h2F; c.shft = 7'h3F; end
				8'h20: c.norm = 7'h20;
				8'h6F: c.norm = 7'h2F;
				8'h6A: c.norm = 7'h2A;
				8'h6D: c.norm = 7'h2D;
				8'h6B: c.norm = 7'h2B;
				8'h60: c.nlck = 7'h30;
				8'h61: c.nlck = 7'h31;
				8'h62: c.nlck = 7'h32;
				8'h63: c.nlck = 7'h33;
				8'h64: c.nlck = 7'h34;
				8'h65: c.nlck = 7'h35;
				8'h66: c.nlck = 7'h36;
				8'h67: c.nlck = 7'h37;
				8'h68: c.nlck = 7'h38;
				8'h69: c.nlck = 7'h39;
				8'h6E: c.nlck = 7'h2E;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

endpackage

FILE: rtl/sc1kd_in_if.sv
interface sc1kd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_byte;

	modport source (output valid, output scan_byte, input ready);
	modport sink (input valid, input scan_byte, output ready);
endinterface

FILE: rtl/sc1kd_out_if.sv
interface sc1kd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] vk_code;
	logic [6:0] ascii;
	logic       released;
	logic       alt_held;
	logic       ctrl_held;
	logic       shift_held;

	modport source (output valid, output vk_code, output ascii, output released,
		output alt_held, output ctrl_held, output shift_held, input ready);
	modport sink (input valid, input vk_code, input ascii, input released,
		input alt_held, input ctrl_held, input shift_held, output ready);
endinterface

FILE: rtl/sc1kd_cfg_if.sv
interface sc1kd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sc1kd_pkg::CFG_IDX_W-1:0] index;
	logic                           data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sc1kd_decode.sv
// Table lookup, modifier update and character pick for one scan byte.
module sc1kd_decode (
	input  logic [7:0]         scan_byte,
	input  sc1kd_pkg::mods_t   mods,
	input  logic               key_down_en,
	input  logic               key_up_en,
	output sc1kd_pkg::mods_t   mods_nxt,
	output sc1kd_pkg::result_t res,
	output logic               emit
);

	logic              is_prefix;
	logic              rel;
	logic [6:0]        idx;
	logic [7:0]        vk;
	sc1kd_pkg::chars_t cols;
	logic [6:0]        ch;

	assign is_prefix = (scan_byte == sc1kd_pkg::PREFIX_BYTE);
	assign rel       = |(scan_byte & sc1kd_pkg::RELEASE_BIT);
	assign idx       = 7'(scan_byte & sc1kd_pkg::INDEX_MASK);
	assign vk        = mods.ext ? sc1kd_pkg::ext_vk(idx) : sc1kd_pkg::plain_vk(idx);

	always_comb begin
		mods_nxt = mods;
		if (is_prefix) begin
			mods_nxt.ext = 1'b1;
		end else begin
			mods_nxt.ext = 1'b0;
			case (vk)
				sc1kd_pkg::VK_LCONTROL, sc1kd_pkg::VK_RCONTROL: mods_nxt.ctrl = !rel;
				sc1kd_pkg::VK_MENU, sc1kd_pkg::VK_LMENU: mods_nxt.alt = !rel;
				sc1kd_pkg::VK_LSHIFT, sc1kd_pkg::VK_RSHIFT: mods_nxt.shift = !rel;
				sc1kd_pkg::VK_LWIN, sc1kd_pkg::VK_RWIN: mods_nxt.win = !rel;
				sc1kd_pkg::VK_CAPITAL: mods_nxt.caps = mods.caps ^ rel;
				sc1kd_pkg::VK_NUMLOCK: mods_nxt.num = mods.num ^ rel;
				sc1kd_pkg::VK_SCROLL: mods_nxt.scroll = mods.scroll ^ rel;
				default: ;
			endcase
		end
	end

	// Priority uses the updated modifiers: numlock, caps, shift.
	assign cols = sc1kd_pkg::char_cols(vk);

	always_comb begin
		if (mods_nxt.num && cols.nlck != 7'd0) begin
			ch = cols.nlck;
		end else if (mods_nxt.caps && cols.caps != 7'd0) begin
			ch = mods_nxt.shift ? cols.norm : cols.caps;
		end else if (mods_nxt.shift && cols.shft != 7'd0) begin
			ch = cols.shft;
		end else begin
			ch = cols.norm;
		end
	end

	assign emit = !is_prefix && (rel ? key_up_en : key_down_en);

	assign res.vk_code    = vk;
	assign res.ascii      = ch;
	assign res.released   = rel;
	assign res.alt_held   = mods_nxt.alt;
	assign res.ctrl_held  = mods_nxt.ctrl;
	assign res.shift_held = mods_nxt.shift;

endmodule

FILE: rtl/scan_code_set1_key_decoder.sv
// Set-1 scan byte to virtual key and ASCII decoder.
// Path: input register, one decode level, result register.
// Throughput: one byte per cycle unless a stalled result holds the input register.
// A stalled result blocks the input only when the byte in the input register emits.
// arst_n clears the enables, the modifier and lock flags and all valid flags.
`include "assert_macros.svh"

module scan_code_set1_key_decoder (
	input  logic               clk,
	input  logic               arst_n,
	sc1kd_in_if.sink           key_in,
	sc1kd_out_if.source        key_out,
	sc1kd_cfg_if.sink          cfg
);

	logic               key_down_en_q;
	logic               key_up_en_q;
	sc1kd_pkg::mods_t   mods_q;
	sc1kd_pkg::mods_t   mods_nxt;

	logic               valid_s1;
	logic [7:0]         byte_s1;

	sc1kd_pkg::result_t res;
	logic               emit;
	logic               out_free;
	logic               s1_go;

	logic               out_valid_q;
	sc1kd_pkg::result_t res_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_down_en_q <= 1'b0;
			key_up_en_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (sc1kd_pkg::cfg_reg_t'(cfg.index))
				sc1kd_pkg::REG_KEY_DOWN_EN: key_down_en_q <= cfg.data;
				sc1kd_pkg::REG_KEY_UP_EN:   key_up_en_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	sc1kd_decode u_decode (
		.scan_byte   (byte_s1),
		.mods        (mods_q),
		.key_down_en (key_down_en_q),
		.key_up_en   (key_up_en_q),
		.mods_nxt    (mods_nxt),
		.res         (res),
		.emit        (emit)
	);

	assign out_free     = !out_valid_q || key_out.ready;
	assign s1_go        = valid_s1 && (!emit || out_free);
	assign key_in.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.ready && key_in.valid) begin
			byte_s1 <= key_in.scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
		end else if (s1_go) begin
			mods_q <= mods_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			res_q <= res;
		end
	end

	assign key_out.valid      = out_valid_q;
	assign key_out.vk_code    = res_q.vk_code;
	assign key_out.ascii      = res_q.ascii;
	assign key_out.released   = res_q.released;
	assign key_out.alt_held   = res_q.alt_held;
	assign key_out.ctrl_held  = res_q.ctrl_held;
	assign key_out.shift_held = res_q.shift_held;

	`SC_ASSERT(a_prefix_sets_ext, clk, arst_n,
		(s1_go && byte_s1 == sc1kd_pkg::PREFIX_BYTE) |=> mods_q.ext,
		"prefix byte did not set the extension flag")
	`SC_ASSERT(a_key_clears_ext, clk, arst_n,
		(s1_go && byte_s1 != sc1kd_pkg::PREFIX_BYTE) |=> !mods_q.ext,
		"extension flag survived a key byte")
	`SC_ASSERT(a_emit_dir, clk, arst_n,
		(s1_go && emit) |=> (out_valid_q && res_q.released == $past(byte_s1[7])),
		"emitted word lost or has wrong direction")
	`SC_ASSERT(a_locks_on_release, clk, arst_n,
		!$stable(mods_q.caps) |-> $past(s1_go && byte_s1[7]),
		"caps lock changed without a release")

endmodule
